>>> sv/utf8_to_ascii_transliterator_macros.svh
// assertion macros for the utf-8 to ascii transliterator
`ifndef UTF8_TO_ASCII_TRANSLITERATOR_MACROS_SVH
`define UTF8_TO_ASCII_TRANSLITERATOR_MACROS_SVH

// property that must hold at every clock edge outside reset
`define U2A_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// same-cycle implication
`define U2A_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define U2A_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/u2a_pkg.sv
// types, constants and replacement table for the utf-8 to ascii transliterator
`default_nettype none

package u2a_pkg;

    localparam logic [7:0]  LEAD_C2       = 8'hC2;
    localparam logic [7:0]  LEAD_C3       = 8'hC3;
    localparam logic [7:0]  LEAD_C5       = 8'hC5;
    localparam logic [7:0]  LEAD_E2       = 8'hE2;
    localparam logic [7:0]  MASK_4BYTE    = 8'hF8;
    localparam logic [7:0]  PAT_4BYTE     = 8'hF0;
    localparam logic [7:0]  MASK_3BYTE    = 8'hF0;
    localparam logic [7:0]  PAT_3BYTE     = 8'hE0;
    localparam logic [7:0]  MASK_2BYTE    = 8'hE0;
    localparam logic [7:0]  PAT_2BYTE     = 8'hC0;
    localparam logic [7:0]  ASCII_TOP     = 8'h80;
    localparam logic [6:0]  CHAR_QUESTION = 7'h3F;
    localparam logic [15:0] MAX_CHARS_RST = 16'd511;
    localparam int          BUF_DEPTH     = 4;

    // up to four replacement characters, first one in ch[0]
    typedef struct packed {
        logic [2:0]      len;
        logic [3:0][6:0] ch;
    } rep_t;

    // one result word
    typedef struct packed {
        logic [6:0] ch;
        logic       eot;
        logic       last;
    } res_t;

    function automatic rep_t mk_rep(input logic [2:0] n, input logic [7:0] c0,
                                    input logic [7:0] c1, input logic [7:0] c2,
                                    input logic [7:0] c3);
        rep_t r;
        r.len   = n;
        r.ch[0] = c0[6:0];
        r.ch[1] = c1[6:0];
        r.ch[2] = c2[6:0];
        r.ch[3] = c3[6:0];
        return r;
    endfunction

    function automatic rep_t rep_one(input logic [7:0] c0);
        return mk_rep(3'd1, c0, 8'h00, 8'h00, 8'h00);
    endfunction

    function automatic rep_t rep_two(input logic [7:0] c0, input logic [7:0] c1);
        return mk_rep(3'd2, c0, c1, 8'h00, 8'h00);
    endfunction

    // replacement for a completed sequence; unknown sequences give '?'
    function automatic rep_t rep_lookup(input logic [7:0] lead, input logic [7:0] ff,
                                        input logic [7:0] b);
        rep_t r;
        r = rep_one("?");
        case (lead)
            LEAD_C2:
            begin
                case (b)
                    8'hA0:   r = rep_one(" ");
                    8'hB0:   r = mk_rep(3'd4, " ", "d", "e", "g");
                    8'hB1:   r = mk_rep(3'd3, "+", "/", "-", 8'h00);
                    8'hB7:   r = rep_one("-");
                    default: r = rep_one("?");
                endcase
            end
            LEAD_C3:
            begin
                if (b inside {[8'h80:8'h85]})                    r = rep_one("A");
                else if (b == 8'h86)                              r = rep_two("A", "E");
                else if (b == 8'h87)                              r = rep_one("C");
                else if (b inside {[8'h88:8'h8B]})               r = rep_one("E");
                else if (b inside {[8'h8C:8'h8F]})               r = rep_one("I");
                else if (b == 8'h91)                              r = rep_one("N");
                else if (b inside {[8'h92:8'h96], 8'h98})        r = rep_one("O");
                else if (b inside {[8'h99:8'h9C]})               r = rep_one("U");
                else if (b == 8'h9D)                              r = rep_one("Y");
                else if (b == 8'h9F)                              r = rep_two("s", "s");
                else if (b inside {[8'hA0:8'hA5]})               r = rep_one("a");
                else if (b == 8'hA6)                              r = rep_two("a", "e");
                else if (b == 8'hA7)                              r = rep_one("c");
                else if (b inside {[8'hA8:8'hAB]})               r = rep_one("e");
                else if (b inside {[8'hAC:8'hAF]})               r = rep_one("i");
                else if (b == 8'hB1)                              r = rep_one("n");
                else if (b inside {[8'hB2:8'hB6], 8'hB8})        r = rep_one("o");
                else if (b inside {[8'hB9:8'hBC]})               r = rep_one("u");
                else if (b inside {8'hBD, 8'hBF})                r = rep_one("y");
                else                                              r = rep_one("?");
            end
            LEAD_C5:
            begin
                case (b)
                    8'h92:   r = rep_two("O", "E");
                    8'h93:   r = rep_two("o", "e");
                    default: r = rep_one("?");
                endcase
            end
            LEAD_E2:
            begin
                if (ff == 8'h80)
                begin
                    if (b inside {[8'h90:8'h94], 8'hA2}) r = rep_one("-");
                    else if (b inside {8'h98, 8'h99})    r = rep_one("'");
                    else if (b inside {8'h9C, 8'h9D})    r = rep_one("\"");
                    else if (b == 8'hA6)                  r = mk_rep(3'd3, ".", ".", ".", 8'h00);
                    else                                  r = rep_one("?");
                end
                else if (ff == 8'h86)
                begin
                    if (b == 8'h90)      r = rep_two("<", "-");
                    else if (b == 8'h92) r = rep_two("-", ">");
                    else                 r = rep_one("?");
                end
                else if (ff == 8'h9A && b == 8'hA0) r = rep_one("!");
                else if (ff == 8'h9C && b == 8'h93) r = rep_two("O", "K");
                else                                 r = rep_one("?");
            end
            default: r = rep_one("?");
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

>>> sv/utf8_to_ascii_transliterator.sv
// utf-8 to ascii transliterator top level
// path: result words go through the four-entry result buffer into the output register
// throughput: one byte per cycle while each byte yields at most one word and the
//   output is not stalled; a byte yielding more words (up to four) holds the input
//   until the result buffer, which drains one word per cycle, holds its last word
// reset: rst_n clears the parser state, the character count, the buffer and the
//   output valid, and sets max_chars to 511; no clearing pass is needed
`default_nettype none

`include "utf8_to_ascii_transliterator_macros.svh"

module utf8_to_ascii_transliterator (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration write channel
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data,       // max_chars
    // input byte stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // text_byte
    // output character stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // out_char[6:0], zero pad [7]
    output logic [0:0]       m_axis_tuser,   // end_of_text
    output logic             m_axis_tlast    // last_of_run
);
    import u2a_pkg::*;

    logic [15:0]            max_chars_reg;
    logic [7:0]             lead_reg, lead_next;
    logic [7:0]             ff_reg, ff_next;
    logic [1:0]             bytes_left_reg, bytes_left_next;
    logic [15:0]            chars_written_reg, chars_written_next;
    logic [2:0]             buf_cnt_reg, buf_cnt_next;
    res_t [BUF_DEPTH-1:0]   buf_reg, buf_next;
    logic                   out_valid_reg, out_valid_next;
    res_t                   out_reg, out_next;

    logic                   pop;
    logic                   accept;
    logic [7:0]             b;
    rep_t                   rep;
    logic [15:0]            room;
    logic [2:0]             keep;
    res_t [BUF_DEPTH-1:0]   ent_new;
    logic [2:0]             cnt_new;
    logic                   cut_q;

    assign cfg_ready     = 1'b1;
    assign pop           = (buf_cnt_reg != 3'd0) && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = (buf_cnt_reg == 3'd0) || ((buf_cnt_reg == 3'd1) && pop);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign b             = s_axis_tdata;
    assign room          = (chars_written_reg < max_chars_reg) ?
                           (max_chars_reg - chars_written_reg) : 16'd0;

    // parse one byte
    always_comb
    begin
        lead_next       = lead_reg;
        ff_next         = ff_reg;
        bytes_left_next = bytes_left_reg;
        rep             = mk_rep(3'd0, 8'h00, 8'h00, 8'h00, 8'h00);
        if (b == 8'h00)
        begin
            lead_next       = 8'h00;
            ff_next         = 8'h00;
            bytes_left_next = 2'd0;
        end
        else if (bytes_left_reg == 2'd0)
        begin
            if (b < ASCII_TOP)
            begin
                rep = rep_one(b);
            end
            else if (b inside {LEAD_C2, LEAD_C3, LEAD_C5})
            begin
                lead_next       = b;
                bytes_left_next = 2'd1;
            end
            else if (b == LEAD_E2)
            begin
                lead_next       = b;
                bytes_left_next = 2'd2;
            end
            else if ((b & MASK_4BYTE) == PAT_4BYTE)
            begin
                lead_next       = b;
                bytes_left_next = 2'd3;
            end
            else if ((b & MASK_3BYTE) == PAT_3BYTE)
            begin
                lead_next       = b;
                bytes_left_next = 2'd2;
            end
            else if ((b & MASK_2BYTE) == PAT_2BYTE)
            begin
                lead_next       = b;
                bytes_left_next = 2'd1;
            end
            else
            begin
                rep = rep_one("?");
            end
        end
        else
        begin
            bytes_left_next = bytes_left_reg - 2'd1;
            if (bytes_left_next != 2'd0)
            begin
                if (lead_reg == LEAD_E2 && bytes_left_next == 2'd1)
                begin
                    ff_next = b;
                end
            end
            else
            begin
                rep       = rep_lookup(lead_reg, ff_reg, b);
                lead_next = 8'h00;
                ff_next   = 8'h00;
            end
        end
    end

    // apply the character limit and build the result words
    always_comb
    begin
        keep  = (room >= 16'(rep.len)) ? rep.len : room[2:0];
        cut_q = (bytes_left_reg != 2'd0) && (room != 16'd0);
        for (int i = 0; i < BUF_DEPTH; i++)
        begin
            ent_new[i].ch   = rep.ch[i];
            ent_new[i].eot  = 1'b0;
            ent_new[i].last = (3'(i) + 3'd1 == keep);
        end
        if (b == 8'h00)
        begin
            ent_new[0].ch   = cut_q ? CHAR_QUESTION : 7'h00;
            ent_new[0].eot  = !cut_q;
            ent_new[0].last = !cut_q;
            ent_new[1].ch   = 7'h00;
            ent_new[1].eot  = 1'b1;
            ent_new[1].last = 1'b1;
            cnt_new            = cut_q ? 3'd2 : 3'd1;
            chars_written_next = 16'd0;
        end
        else
        begin
            cnt_new            = keep;
            chars_written_next = chars_written_reg + 16'(keep);
        end
    end

    // buffer and output register
    always_comb
    begin
        buf_cnt_next   = buf_cnt_reg;
        buf_next       = buf_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (pop)
        begin
            out_valid_next = 1'b1;
            out_next       = buf_reg[0];
            buf_cnt_next   = buf_cnt_reg - 3'd1;
            for (int i = 0; i < BUF_DEPTH - 1; i++)
            begin
                buf_next[i] = buf_reg[i+1];
            end
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (accept)
        begin
            buf_next     = ent_new;
            buf_cnt_next = cnt_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_chars_reg     <= MAX_CHARS_RST;
            lead_reg          <= 8'h00;
            ff_reg            <= 8'h00;
            bytes_left_reg    <= 2'd0;
            chars_written_reg <= 16'd0;
            buf_cnt_reg       <= 3'd0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                max_chars_reg <= cfg_data;
            end
            if (accept)
            begin
                lead_reg          <= lead_next;
                ff_reg            <= ff_next;
                bytes_left_reg    <= bytes_left_next;
                chars_written_reg <= chars_written_next;
            end
            buf_cnt_reg   <= buf_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
        out_reg <= out_next;
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = {1'b0, out_reg.ch};
    assign m_axis_tuser[0] = out_reg.eot;
    assign m_axis_tlast    = out_reg.last;

    `U2A_ASSERT_ALWAYS(a_buf_depth, buf_cnt_reg <= 3'(BUF_DEPTH), "buffer count overflow")
    `U2A_ASSERT_IMPL(a_ready_room, s_axis_tready, buf_cnt_reg <= 3'd1,
        "input ready while buffer holds more than one word")
    `U2A_ASSERT_IMPL(a_eot_last, m_axis_tvalid && m_axis_tuser[0],
        m_axis_tlast && (m_axis_tdata == 8'h00), "terminator word not closing its run")
    `U2A_ASSERT_NEXT(a_term_clears, s_axis_tvalid && s_axis_tready && (s_axis_tdata == 8'h00),
        (bytes_left_reg == 2'd0) && (chars_written_reg == 16'd0) && (lead_reg == 8'h00),
        "terminator did not clear parser state")

endmodule

`default_nettype wire
